// ----- src/sspd_pkg.sv -----
package sspd_pkg;

    // Leg geometry is fixed: abduction, flexion, knee
    localparam int JOINTS_PER_LEG = 3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        JT_ABD  = 2'd0,
        JT_FLEX = 2'd1,
        JT_KNEE = 2'd2
    } jtype_t;

    typedef enum logic [3:0] {
        REG_POS_GAIN  = 4'd0,
        REG_DAMP_GAIN = 4'd1,
        REG_DURATION  = 4'd2,
        REG_TRQ_LIM   = 4'd3,
        REG_ABD_LIM   = 4'd4,
        REG_ABD_TGT   = 4'd5,
        REG_FLEX_TGT  = 4'd6,
        REG_KNEE_TGT  = 4'd7
    } reg_idx_t;

    // Configuration as seen by front and back
    typedef struct packed {
        logic [15:0]        kp;
        logic [15:0]        kd;
        logic [15:0]        dur;
        logic [14:0]        tlim;
        logic [14:0]        alim;
        logic [14:0]        atgt;
        logic signed [15:0] ftgt;
        logic signed [15:0] ktgt;
    } cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [3:0]         idx;
        logic signed [15:0] pos;
        logic signed [15:0] vel;
        logic [15:0]        el;
        logic signed [15:0] startp;
        logic signed [16:0] target;
        logic [14:0]        limit;
        logic               done;
    } entry_t;

    // Leg number of a joint index (index / 3)
    function automatic logic [3:0] leg_of(input logic [3:0] idx);
        case (idx) inside
            [4'd0:4'd2]:   leg_of = 4'd0;
            [4'd3:4'd5]:   leg_of = 4'd1;
            [4'd6:4'd8]:   leg_of = 4'd2;
            [4'd9:4'd11]:  leg_of = 4'd3;
            [4'd12:4'd14]: leg_of = 4'd4;
            default:       leg_of = 4'd5;
        endcase
    endfunction

    // Joint type within the leg (index mod 3)
    function automatic jtype_t type_of(input logic [3:0] idx);
        logic [3:0] leg;
        leg = leg_of(idx);
        type_of = jtype_t'(2'(idx - 4'({leg, 1'b0}) - leg));
    endfunction

endpackage

// ----- src/sspd_in_if.sv -----
interface sspd_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         joint_sel;
    logic signed [15:0] measured_position;
    logic signed [15:0] measured_rate;
    logic [15:0]        elapsed_ms;
    logic               start_ramp;

    modport source (output valid, joint_sel, measured_position, measured_rate,
                    elapsed_ms, start_ramp, input ready);
    modport sink   (input valid, joint_sel, measured_position, measured_rate,
                    elapsed_ms, start_ramp, output ready);
endinterface

// ----- src/sspd_out_if.sv -----
interface sspd_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         joint_out;
    logic signed [15:0] torque_command;
    logic signed [15:0] desired_position;
    logic signed [15:0] desired_velocity;
    logic               ramp_done;
    logic               torque_saturated;

    modport source (output valid, joint_out, torque_command, desired_position,
                    desired_velocity, ramp_done, torque_saturated, input ready);
    modport sink   (input valid, joint_out, torque_command, desired_position,
                    desired_velocity, ramp_done, torque_saturated, output ready);
endinterface

// ----- src/sspd_cfg_if.sv -----
interface sspd_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/sspd_front.sv -----
module sspd_front #(
    parameter int NUM_JOINTS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    sspd_in_if.sink          in_ch,
    input  sspd_pkg::cfg_t   cfg,
    output sspd_pkg::entry_t push_data,
    output logic             push,
    input  logic             full
);

    localparam int AW        = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int LEFT_LEGS = (NUM_JOINTS / sspd_pkg::JOINTS_PER_LEG) / 2;

    logic                  acc;
    logic                  jv_in;
    logic [AW-1:0]         addr_in;

    // start store and its written marks
    logic signed [15:0]    start_mem [NUM_JOINTS];
    logic [NUM_JOINTS-1:0] seen_reg;

    // accept stage
    logic                  a_vld_reg;
    logic [3:0]            a_idx_reg;
    logic signed [15:0]    a_pos_reg;
    logic signed [15:0]    a_vel_reg;
    logic [15:0]           a_el_reg;
    logic                  a_start_reg;
    logic                  a_jv_reg;
    logic signed [15:0]    rd_reg;
    logic                  rdv_reg;

    logic [3:0]            leg;
    sspd_pkg::jtype_t      jt;
    logic                  left;

    assign acc          = in_ch.valid && in_ch.ready;
    assign jv_in        = 6'(in_ch.joint_sel) < 6'(NUM_JOINTS);
    assign addr_in      = AW'(in_ch.joint_sel);
    assign in_ch.ready  = !a_vld_reg || !full;
    assign push         = a_vld_reg && !full;

    // store write and registered read
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rd_reg <= start_mem[addr_in];
        end
        if (acc && jv_in && in_ch.start_ramp)
        begin
            start_mem[addr_in] <= in_ch.measured_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            a_vld_reg <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            if (acc && jv_in && in_ch.start_ramp)
            begin
                seen_reg[addr_in] <= 1'b1;
            end
            if (acc)
            begin
                a_vld_reg <= 1'b1;
                rdv_reg   <= jv_in && seen_reg[addr_in];
            end
            else if (push)
            begin
                a_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_idx_reg   <= in_ch.joint_sel;
            a_pos_reg   <= in_ch.measured_position;
            a_vel_reg   <= in_ch.measured_rate;
            a_el_reg    <= in_ch.elapsed_ms;
            a_start_reg <= in_ch.start_ramp;
            a_jv_reg    <= jv_in;
        end
    end

    // classify: start, target, limit, done
    always_comb
    begin
        leg  = sspd_pkg::leg_of(a_idx_reg);
        jt   = sspd_pkg::type_of(a_idx_reg);
        left = 5'(leg) < 5'(LEFT_LEGS);

        push_data.idx  = a_idx_reg;
        push_data.pos  = a_pos_reg;
        push_data.vel  = a_vel_reg;
        push_data.el   = a_el_reg;
        push_data.done = a_el_reg >= cfg.dur;

        if (!a_jv_reg)
            push_data.startp = '0;
        else if (a_start_reg)
            push_data.startp = a_pos_reg;
        else if (rdv_reg)
            push_data.startp = rd_reg;
        else
            push_data.startp = '0;

        unique case (jt)
            sspd_pkg::JT_ABD:
            begin
                push_data.target = left ? 17'sd0 - $signed({2'b0, cfg.atgt})
                                        : $signed({2'b0, cfg.atgt});
                push_data.limit  = cfg.alim;
            end
            sspd_pkg::JT_FLEX:
            begin
                push_data.target = 17'(cfg.ftgt);
                push_data.limit  = cfg.tlim;
            end
            default:
            begin
                push_data.target = 17'(cfg.ktgt);
                push_data.limit  = cfg.tlim;
            end
        endcase
    end

endmodule

// ----- src/sspd_queue.sv -----
module sspd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sspd_pkg::entry_t push_data,
    input  logic             pop,
    output sspd_pkg::entry_t head,
    output logic             empty,
    output logic             full
);

    localparam int PW = $clog2(sspd_pkg::QUEUE_DEPTH);

    sspd_pkg::entry_t entry_reg [sspd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign empty = count_reg == '0;
    assign full  = count_reg == (PW+1)'(sspd_pkg::QUEUE_DEPTH);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- src/sspd_back.sv -----
module sspd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sspd_pkg::cfg_t   cfg,
    input  sspd_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    sspd_out_if.source       out_ch
);

    localparam int S_LOAD  = 0;
    localparam int S_DIV1  = 1;
    localparam int S_SQ    = 17;
    localparam int S_SH    = 18;
    localparam int S_MUL   = 19;
    localparam int S_SCALE = 20;
    localparam int S_D2I   = 21;
    localparam int S_DIV2  = 22;
    localparam int S_VEL   = 38;
    localparam int S_PD    = 39;
    localparam int S_OUT   = 40;
    localparam int NST     = 41;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [15:0] pos;
        logic signed [15:0] vel;
        logic [15:0]        el;
        logic signed [15:0] startp;
        logic [14:0]        limit;
        logic               done;
        logic signed [17:0] delta;
        logic [16:0]        dmag;
        logic               dneg;
        logic [16:0]        rem;
        logic [15:0]        q;
        logic [33:0]        pp;
        logic [32:0]        ppm;
        logic [17:0]        k3;
        logic [16:0]        p2;
        logic [16:0]        slope;
        logic [34:0]        ap;
        logic [33:0]        sd;
        logic [16:0]        alpha;
        logic [22:0]        m;
        logic signed [35:0] ad;
        logic               ovf;
        logic signed [15:0] pdes;
        logic signed [15:0] vdes;
        logic signed [33:0] tp;
        logic signed [33:0] td;
        logic signed [15:0] torque;
        logic               sat;
    } work_t;

    work_t          st_reg  [NST];
    work_t          st_next [NST];
    logic [NST-1:0] vld_reg;
    logic           adv;

    // one restoring divide step: {remainder, quotient bit}
    function automatic logic [17:0] dstep(input logic [16:0] r, input logic b,
                                          input logic [15:0] d);
        logic [16:0] r2;
        r2 = {r[15:0], b};
        if (r2 >= {1'b0, d})
            dstep = {r2 - {1'b0, d}, 1'b1};
        else
            dstep = {r2, 1'b0};
    endfunction

    assign adv = !vld_reg[NST-1] || out_ch.ready;
    assign pop = adv && !empty;

    // load: error span and first divider remainder
    always_comb
    begin
        st_next[S_LOAD]        = '0;
        st_next[S_LOAD].idx    = head.idx;
        st_next[S_LOAD].pos    = head.pos;
        st_next[S_LOAD].vel    = head.vel;
        st_next[S_LOAD].el     = head.el;
        st_next[S_LOAD].startp = head.startp;
        st_next[S_LOAD].limit  = head.limit;
        st_next[S_LOAD].done   = head.done;
        st_next[S_LOAD].delta  = 18'(head.target) - 18'(head.startp);
        st_next[S_LOAD].dneg   = st_next[S_LOAD].delta[17];
        st_next[S_LOAD].dmag   = st_next[S_LOAD].dneg ? 17'(-st_next[S_LOAD].delta)
                                                      : 17'(st_next[S_LOAD].delta);
        st_next[S_LOAD].rem    = {1'b0, head.el};
        st_next[S_LOAD].q      = '0;
    end

    // phase divider: elapsed * 2^16 / duration
    for (genvar k = 0; k < 16; k++)
    begin : g_div1
        always_comb
        begin
            logic [17:0] s;
            st_next[S_DIV1+k]     = st_reg[S_DIV1+k-1];
            s                     = dstep(st_reg[S_DIV1+k-1].rem, 1'b0, cfg.dur);
            st_next[S_DIV1+k].rem = s[17:1];
            st_next[S_DIV1+k].q   = {st_reg[S_DIV1+k-1].q[14:0], s[0]};
        end
    end

    // phase products
    always_comb
    begin
        logic [16:0] p;
        st_next[S_SQ]     = st_reg[S_SQ-1];
        p                 = st_reg[S_SQ-1].done ? 17'h10000 : {1'b0, st_reg[S_SQ-1].q};
        st_next[S_SQ].pp  = 34'(p) * 34'(p);
        st_next[S_SQ].ppm = 33'(p) * 33'(17'h10000 - p);
        st_next[S_SQ].k3  = 18'(196608) - 18'({p, 1'b0});
    end

    // square and slope
    always_comb
    begin
        logic [35:0] six;
        st_next[S_SH]       = st_reg[S_SH-1];
        six                 = (36'(st_reg[S_SH-1].ppm) << 2) + (36'(st_reg[S_SH-1].ppm) << 1);
        st_next[S_SH].p2    = st_reg[S_SH-1].pp[32:16];
        st_next[S_SH].slope = 17'(six >> 16);
    end

    always_comb
    begin
        st_next[S_MUL]    = st_reg[S_MUL-1];
        st_next[S_MUL].ap = 35'(st_reg[S_MUL-1].p2) * 35'(st_reg[S_MUL-1].k3);
        st_next[S_MUL].sd = 34'(st_reg[S_MUL-1].slope) * 34'(st_reg[S_MUL-1].dmag);
    end

    // alpha, and velocity numerator times 1000 over 2^20
    always_comb
    begin
        logic [45:0] x;
        st_next[S_SCALE]       = st_reg[S_SCALE-1];
        x = (46'(st_reg[S_SCALE-1].sd) << 10) - (46'(st_reg[S_SCALE-1].sd) << 4)
            - (46'(st_reg[S_SCALE-1].sd) << 3);
        st_next[S_SCALE].alpha = 17'(st_reg[S_SCALE-1].ap >> 16);
        st_next[S_SCALE].m     = 23'(x >> 20);
    end

    // position step, and velocity divider set-up with overflow check
    always_comb
    begin
        st_next[S_D2I]     = st_reg[S_D2I-1];
        st_next[S_D2I].ad  = 36'($signed({1'b0, st_reg[S_D2I-1].alpha}))
                             * 36'(st_reg[S_D2I-1].delta);
        st_next[S_D2I].ovf = 32'(st_reg[S_D2I-1].m) >= {cfg.dur, 16'h0};
        st_next[S_D2I].rem = 17'(st_reg[S_D2I-1].m >> 16);
        st_next[S_D2I].q   = '0;
    end

    // velocity divider over the low 16 bits
    for (genvar k = 0; k < 16; k++)
    begin : g_div2
        always_comb
        begin
            logic [17:0] s;
            st_next[S_DIV2+k]     = st_reg[S_DIV2+k-1];
            s                     = dstep(st_reg[S_DIV2+k-1].rem,
                                          st_reg[S_DIV2+k-1].m[15-k], cfg.dur);
            st_next[S_DIV2+k].rem = s[17:1];
            st_next[S_DIV2+k].q   = {st_reg[S_DIV2+k-1].q[14:0], s[0]};
        end
    end

    // desired position (rounded) and saturated desired velocity
    always_comb
    begin
        logic signed [35:0] rnd;
        work_t              w;
        w   = st_reg[S_VEL-1];
        rnd = (w.ad + 36'sd32768) >>> 16;
        st_next[S_VEL]      = w;
        st_next[S_VEL].pdes = 16'(36'(w.startp) + rnd);
        if (w.done)
            st_next[S_VEL].vdes = '0;
        else if (!w.dneg)
            st_next[S_VEL].vdes = (w.ovf || w.q[15]) ? 16'sd32767 : $signed(w.q);
        else if (w.ovf || (w.q[15] && (w.q[14:0] != '0)))
            st_next[S_VEL].vdes = -16'sd32768;
        else
            st_next[S_VEL].vdes = 16'(-{1'b0, w.q});
    end

    // PD products
    always_comb
    begin
        logic signed [16:0] ep;
        logic signed [16:0] ev;
        st_next[S_PD]    = st_reg[S_PD-1];
        ep               = 17'(st_reg[S_PD-1].pdes) - 17'(st_reg[S_PD-1].pos);
        ev               = 17'(st_reg[S_PD-1].vdes) - 17'(st_reg[S_PD-1].vel);
        st_next[S_PD].tp = 34'(ep) * 34'($signed({1'b0, cfg.kp}));
        st_next[S_PD].td = 34'(ev) * 34'($signed({1'b0, cfg.kd}));
    end

    // torque sum and clip
    always_comb
    begin
        logic signed [37:0] sum;
        logic signed [37:0] t;
        logic signed [37:0] lim;
        st_next[S_OUT] = st_reg[S_OUT-1];
        sum = 38'(st_reg[S_OUT-1].tp) + (38'(st_reg[S_OUT-1].td) <<< 4);
        t   = sum >>> 12;
        lim = $signed({23'b0, st_reg[S_OUT-1].limit});
        if (t > lim)
        begin
            st_next[S_OUT].torque = 16'(lim);
            st_next[S_OUT].sat    = 1'b1;
        end
        else if (t < -lim)
        begin
            st_next[S_OUT].torque = 16'(-lim);
            st_next[S_OUT].sat    = 1'b1;
        end
        else
        begin
            st_next[S_OUT].torque = 16'(t);
            st_next[S_OUT].sat    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], pop};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign out_ch.valid            = vld_reg[NST-1];
    assign out_ch.joint_out        = st_reg[NST-1].idx;
    assign out_ch.torque_command   = st_reg[NST-1].torque;
    assign out_ch.desired_position = st_reg[NST-1].pdes;
    assign out_ch.desired_velocity = st_reg[NST-1].vdes;
    assign out_ch.ramp_done        = st_reg[NST-1].done;
    assign out_ch.torque_saturated = st_reg[NST-1].sat;

endmodule

// ----- src/smoothstep_standup_joint_pd.sv -----
// Throughput: one item per cycle unless out_ch stalls; back pipeline has two 16-step dividers.
// A four-entry queue parts the front from the back, so each side stalls on its own.
// Reset: registers return to defaults, start store marks cleared at once, pipeline empty.
module smoothstep_standup_joint_pd #(
    parameter int NUM_JOINTS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    sspd_in_if.sink    in_ch,
    sspd_out_if.source out_ch,
    sspd_cfg_if.sink   cfg
);

    sspd_pkg::cfg_t   cfg_reg;
    sspd_pkg::entry_t push_data;
    sspd_pkg::entry_t head;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp   <= 16'd8960;
            cfg_reg.kd   <= 16'd461;
            cfg_reg.dur  <= 16'd3000;
            cfg_reg.tlim <= 15'd20480;
            cfg_reg.alim <= 15'd20480;
            cfg_reg.atgt <= 15'd1229;
            cfg_reg.ftgt <= 16'sd2351;
            cfg_reg.ktgt <= -16'sd5623;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sspd_pkg::REG_POS_GAIN:  cfg_reg.kp   <= cfg.data;
                sspd_pkg::REG_DAMP_GAIN: cfg_reg.kd   <= cfg.data;
                sspd_pkg::REG_DURATION:  cfg_reg.dur  <= cfg.data;
                sspd_pkg::REG_TRQ_LIM:   cfg_reg.tlim <= cfg.data[14:0];
                sspd_pkg::REG_ABD_LIM:   cfg_reg.alim <= cfg.data[14:0];
                sspd_pkg::REG_ABD_TGT:   cfg_reg.atgt <= cfg.data[14:0];
                sspd_pkg::REG_FLEX_TGT:  cfg_reg.ftgt <= $signed(cfg.data);
                sspd_pkg::REG_KNEE_TGT:  cfg_reg.ktgt <= $signed(cfg.data);
                default:                 ;
            endcase
        end
    end

    sspd_front #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg_reg),
        .push_data (push_data),
        .push      (push),
        .full      (full)
    );

    sspd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    sspd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
